/* design/ftlm_pkg.sv */
package ftlm_pkg;

    // Default tap count of the filter.
    localparam int TAP_COUNT_DEF = 49;

    // Number of nonzero coefficients; taps beyond this have coefficient zero.
    localparam int COEF_COUNT = 49;
    localparam int COEF_IDX_W = 7;

    localparam int RAW_W    = 13;
    localparam int OFS_W    = 8;
    localparam int X_W      = 14;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int FRAC_W   = 15;
    localparam int LED_W    = 8;
    localparam int LEVEL_W  = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_FILTER = 1'b1;

    localparam logic signed [OFS_W-1:0] OFFSET_RESET = -8'sd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Control handed from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic                  clr;
        logic                  issue;
        logic [COEF_IDX_W-1:0] tap;
    } t_mac_ctrl;

    localparam logic signed [SAMPLE_W-1:0] COEF_TAB [COEF_COUNT] = '{
        16'sd152,   16'sd242,   -16'sd79,   -16'sd233,  16'sd107,   16'sd2,
        -16'sd307,  16'sd130,   16'sd143,   -16'sd436,  16'sd100,   16'sd375,
        -16'sd587,  -16'sd35,   16'sd729,   -16'sd737,  -16'sd356,  16'sd1298,
        -16'sd863,  -16'sd1106, 16'sd2464,  -16'sd947,  -16'sd3944, 16'sd9435,
        16'sd20869, 16'sd9435,  -16'sd3944, -16'sd947,  16'sd2464,  -16'sd1106,
        -16'sd863,  16'sd1298,  -16'sd356,  -16'sd737,  16'sd729,   -16'sd35,
        -16'sd587,  16'sd375,   16'sd100,   -16'sd436,  16'sd143,   16'sd130,
        -16'sd307,  16'sd2,     16'sd107,   -16'sd233,  -16'sd79,   16'sd242,
        16'sd152
    };

    function automatic logic signed [SAMPLE_W-1:0] coef(input logic [COEF_IDX_W-1:0] idx);
        logic signed [SAMPLE_W-1:0] c;
        c = '0;
        if (idx < COEF_IDX_W'(COEF_COUNT)) begin
            c = COEF_TAB[idx[5:0]];
        end
        return c;
    endfunction

    function automatic logic [LED_W-1:0] led_map(input logic [2:0] pos);
        logic [LED_W-1:0] p;
        case (pos)
            3'd0:    p = 8'h08;
            3'd1:    p = 8'h04;
            3'd2:    p = 8'h02;
            3'd3:    p = 8'h01;
            3'd4:    p = 8'h80;
            3'd5:    p = 8'h40;
            3'd6:    p = 8'h20;
            default: p = 8'h10;
        endcase
        return p;
    endfunction

endpackage

/* design/fir_tilt_led_mapper_top.sv */
// Tilt filter and LED mapper. Each input word carries one signed 13-bit
// accelerometer reading; the block adds the signed 8-bit sample_offset
// register and, unless bypass_filter is set, writes the offset sample into a
// TAP_COUNT-entry circular history held in a single-port-read memory and
// convolves the history with fixed symmetric Q1.15 coefficients (taps past
// the 49th have coefficient zero). The 32-bit wrapping sum is shifted right
// by 15 and truncated to a signed 16-bit result; in bypass the offset sample
// itself is the result and the history is untouched. The result also yields
// a one-hot LED position from bits 8..6 and a 5-bit level from bits 5..1.
// A filtered word occupies the block from the cycle that accepts it through
// the history write, one memory read and one multiply-accumulate per tap,
// the drain of the read and multiplier registers, and the load of the output
// register. A bypassed word goes from the accepting cycle to the load. A
// stalled output register holds off the load until it is free. The memory
// read port, one tap per cycle, bounds the filtered path. The next word
// is accepted as soon as the result is loaded, even while that result still
// waits in the output register. The history reads as zeros after reset
// through per-entry valid bits, so no clearing pass is needed.
module fir_tilt_led_mapper_top #(
    parameter int TAP_COUNT = ftlm_pkg::TAP_COUNT_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ftlm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ftlm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [ftlm_pkg::RAW_W-1:0]       i_raw_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ftlm_pkg::SAMPLE_W-1:0]    o_filtered_sample,
    output logic [ftlm_pkg::LED_W-1:0]              o_led_pos,
    output logic [ftlm_pkg::LEVEL_W-1:0]            o_tilt_level
);

    // Address width of the history; a single-entry history still needs one bit.
    localparam int AW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    logic signed [ftlm_pkg::OFS_W-1:0]     r_offset;
    logic                                  r_bypass;
    logic signed [ftlm_pkg::X_W-1:0]       n_x;
    logic signed [ftlm_pkg::SAMPLE_W-1:0]  r_x;
    logic                                  r_item_bypass;
    logic                                  in_accept;
    logic                                  out_free;
    logic                                  load;
    logic                                  mem_we;
    logic [AW-1:0]                         mem_waddr;
    logic                                  mem_re;
    logic [AW-1:0]                         mem_raddr;
    logic signed [ftlm_pkg::SAMPLE_W-1:0]  rd_data;
    ftlm_pkg::t_mac_ctrl                   mac_ctrl;
    logic [ftlm_pkg::ACC_W-1:0]            acc;
    logic signed [ftlm_pkg::SAMPLE_W-1:0]  n_result;
    logic                                  r_out_valid;
    logic signed [ftlm_pkg::SAMPLE_W-1:0]  r_result;

    // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= ftlm_pkg::OFFSET_RESET;
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ftlm_pkg::CFG_SAMPLE_OFFSET: r_offset <= i_cfg_data;
                ftlm_pkg::CFG_BYPASS_FILTER: r_bypass <= i_cfg_data[0];
                default:                     r_bypass <= r_bypass;
            endcase
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;

    // The offset sample spans -4224..4222, so 14 bits hold it without overflow.
    assign n_x = ftlm_pkg::X_W'(i_raw_sample) + ftlm_pkg::X_W'(r_offset);

    // The bypass choice is taken with the word so it stays fixed while it runs.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x           <= ftlm_pkg::SAMPLE_W'(n_x);
            r_item_bypass <= r_bypass;
        end
    end

    // The output register is free when empty or when its word leaves this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    ftlm_ctrl #(
        .TAP_N (TAP_COUNT),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_bypass    (r_bypass),
        .i_out_free  (out_free),
        .o_in_stall  (o_in_stall),
        .o_load      (load),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_mac       (mac_ctrl)
    );

    ftlm_hist_mem #(
        .TAP_N (TAP_COUNT),
        .AW    (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (r_x),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (rd_data)
    );

    ftlm_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mac_ctrl),
        .i_rd_data (rd_data),
        .o_acc     (acc)
    );

    // Arithmetic shift by 15 followed by truncation to 16 bits keeps sum bits 30..15.
    assign n_result = r_item_bypass ? r_x
                    : $signed(acc[ftlm_pkg::FRAC_W+ftlm_pkg::SAMPLE_W-1:ftlm_pkg::FRAC_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_result;
    assign o_led_pos         = ftlm_pkg::led_map(r_result[8:6]);
    assign o_tilt_level      = r_result[5:1];

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a word still waiting");

    a_load_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> o_in_stall)
        else $error("result loaded while the block is idle");

endmodule

/* design/ftlm_hist_mem.sv */
module ftlm_hist_mem #(
    parameter int TAP_N = ftlm_pkg::TAP_COUNT_DEF,
    parameter int AW    = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [AW-1:0]                         i_wr_addr,
    input  logic signed [ftlm_pkg::SAMPLE_W-1:0]  i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [AW-1:0]                         i_rd_addr,
    output logic signed [ftlm_pkg::SAMPLE_W-1:0]  o_rd_data
);

    logic signed [ftlm_pkg::SAMPLE_W-1:0] r_mem [TAP_N];
    logic [TAP_N-1:0]                     r_valid;
    logic signed [ftlm_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                                 r_rd_ok;

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

/* design/ftlm_mac.sv */
module ftlm_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ftlm_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [ftlm_pkg::SAMPLE_W-1:0]  i_rd_data,
    output logic [ftlm_pkg::ACC_W-1:0]            o_acc
);

    logic                                  r_s1_valid;
    logic [ftlm_pkg::COEF_IDX_W-1:0]       r_s1_tap;
    logic                                  r_p_valid;
    logic signed [ftlm_pkg::ACC_W-1:0]     r_prod;
    logic signed [ftlm_pkg::ACC_W-1:0]     n_prod;
    logic [ftlm_pkg::ACC_W-1:0]            r_acc;

    // Stage 1 lines the tap index up with the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            r_s1_valid <= i_ctrl.issue;
            r_p_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tap <= i_ctrl.tap;
        r_prod   <= n_prod;
    end

    assign n_prod = ftlm_pkg::coef(r_s1_tap) * i_rd_data;

    // The sum wraps in 32-bit two's complement.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_p_valid) begin
            r_acc <= r_acc + $unsigned(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

/* design/ftlm_ctrl.sv */
module ftlm_ctrl #(
    parameter int TAP_N = ftlm_pkg::TAP_COUNT_DEF,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_bypass,
    input  logic                 i_out_free,
    output logic                 o_in_stall,
    output logic                 o_load,
    output logic                 o_mem_we,
    output logic [AW-1:0]        o_mem_waddr,
    output logic                 o_mem_re,
    output logic [AW-1:0]        o_mem_raddr,
    output ftlm_pkg::t_mac_ctrl  o_mac
);

    localparam logic [AW-1:0] LAST = AW'(TAP_N - 1);

    ftlm_pkg::t_state r_state;
    ftlm_pkg::t_state n_state;
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_tap;
    logic             r_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftlm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ftlm_pkg::ST_IDLE: begin
                if (i_accept) begin
                    n_state = i_bypass ? ftlm_pkg::ST_DONE : ftlm_pkg::ST_WRITE;
                end
            end
            ftlm_pkg::ST_WRITE: n_state = ftlm_pkg::ST_READ;
            ftlm_pkg::ST_READ: begin
                if (r_tap == LAST) begin
                    n_state = ftlm_pkg::ST_DRAIN;
                end
            end
            ftlm_pkg::ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ftlm_pkg::ST_DONE;
                end
            end
            ftlm_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = ftlm_pkg::ST_IDLE;
                end
            end
            default: n_state = ftlm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_load      = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mac.clr   = 1'b0;
        o_mac.issue = 1'b0;
        o_mac.tap   = ftlm_pkg::COEF_IDX_W'(r_tap);
        case (r_state)
            ftlm_pkg::ST_IDLE:  o_in_stall = 1'b0;
            ftlm_pkg::ST_WRITE: begin
                o_mem_we  = 1'b1;
                o_mac.clr = 1'b1;
            end
            ftlm_pkg::ST_READ: begin
                o_mem_re    = 1'b1;
                o_mac.issue = 1'b1;
            end
            ftlm_pkg::ST_DRAIN: o_load = 1'b0;
            ftlm_pkg::ST_DONE:  o_load = i_out_free;
            default:            o_in_stall = 1'b1;
        endcase
    end

    assign o_mem_waddr = r_wp;
    assign o_mem_raddr = r_rd_addr;

    // Write pointer, read address walking backward from the newest sample, and tap index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_tap   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_drain <= (r_state == ftlm_pkg::ST_DRAIN) ? !r_drain : 1'b0;
            if (r_state == ftlm_pkg::ST_WRITE) begin
                r_wp      <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
                r_rd_addr <= r_wp;
                r_tap     <= '0;
            end else if (r_state == ftlm_pkg::ST_READ) begin
                r_rd_addr <= (r_rd_addr == '0) ? LAST : r_rd_addr - 1'b1;
                r_tap     <= r_tap + 1'b1;
            end
        end
    end

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST)
        else $error("write pointer beyond the history");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ftlm_pkg::ST_READ) |-> (r_tap <= LAST))
        else $error("tap index beyond the history");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ftlm_pkg::ST_DRAIN) |-> ($past(r_tap) == LAST))
        else $error("drain entered before the last tap");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ftlm_pkg::ST_WRITE) |=> (r_state == ftlm_pkg::ST_READ) && !o_mem_we)
        else $error("history written more than once per word");

endmodule
